FILE: hdl/md5_chained_seed_expander_defines.svh
// assertion macros for the checker file
`ifndef MD5_CHAINED_SEED_EXPANDER_DEFINES_SVH
`define MD5_CHAINED_SEED_EXPANDER_DEFINES_SVH

// same-cycle implication, inactive during reset
`define MD5CSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md5cse check failed");

// next-cycle implication, inactive during reset
`define MD5CSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md5cse check failed");

`endif

FILE: hdl/md5cse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package md5cse_pkg;

	localparam int FIRST_SLOT  = 8;
	localparam int SLOT_COUNT  = 64;
	localparam int MAX_RESULTS = 56;
	localparam int MSG_BYTES   = 16;

	// slot group counter, wide enough to step past the last group
	localparam int GROUP_W = 7;
	localparam bit RANGE_NONEMPTY = (FIRST_SLOT < SLOT_COUNT);

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// padding words of a 16-byte single-block message
	localparam logic [31:0] PAD_WORD = 32'h00000080;
	localparam logic [31:0] LEN_WORD = 32'(MSG_BYTES * 8);

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] MD5_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_INIT   = 5'b00010,
		S_ROUND  = 5'b00100,
		S_FINISH = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic       load_seed;
		logic       start;
		logic       round;
		logic       finish;
		logic [1:0] word_sel;
		logic [7:0] group_byte;
	} cmd_t;

	typedef struct packed {
		logic last_round;
	} sts_t;

endpackage
`default_nettype wire

FILE: hdl/md5_chained_seed_expander.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake            | payload
// --------+----------------------+-------------------------------------
// input   | in_valid / in_ready  | seed[31:0]
// output  | out_valid / out_ready| slot_index[5:0] slot_word[31:0] last_word
//
// one seed is taken only while the block is idle; it then yields 56 items
// each digest passes set-up, 64 rounds on one shared round unit and a final add,
// and each of its four words is then offered in turn on the output register,
// so a seed takes 14 chained digests plus any output stall,
// and the block returns to idle after the last item before the next seed can be taken
// reset clears the controller and the round counter; message and digest registers need none
// a stalled output item holds; input stays blocked until the last item is taken
module md5_chained_seed_expander (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] seed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       slot_index,
	output logic [31:0]      slot_word,
	output logic             last_word
);

	// commands to the datapath, status back
	md5cse_pkg::cmd_t cmd;
	md5cse_pkg::sts_t sts;

	// sequencer: slot groups, round counting, result hand-off
	md5cse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_index (slot_index),
		.last_word  (last_word),
		.cmd        (cmd),
		.sts        (sts)
	);

	// message, md5 round unit and digest words
	md5cse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed),
		.cmd       (cmd),
		.sts       (sts),
		.slot_word (slot_word)
	);

endmodule
`default_nettype wire

FILE: hdl/md5cse_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module md5cse_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [31:0]       seed,
	input  wire md5cse_pkg::cmd_t  cmd,
	output md5cse_pkg::sts_t       sts,
	output logic [31:0]            slot_word
);

	logic [31:0] seed_q;
	logic [31:0] msg_q [4];
	logic [31:0] hash_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  round_q;

	logic [1:0]  phase;
	logic [3:0]  g_idx;
	logic [31:0] f_val;
	logic [31:0] m_word;
	logic [31:0] sum;
	logic [63:0] rot_wide;
	logic [31:0] new_b;
	logic [31:0] fin [4];

	assign phase = round_q[5:4];

	always_comb begin
		unique case (phase)
			2'd0: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				g_idx = round_q[3:0];
			end
			2'd1: begin
				f_val = (d_q & b_q) | (~d_q & c_q);
				g_idx = 4'(5 * round_q + 1);
			end
			2'd2: begin
				f_val = b_q ^ c_q ^ d_q;
				g_idx = 4'(3 * round_q + 5);
			end
			default: begin
				f_val = c_q ^ (b_q | ~d_q);
				g_idx = 4'(7 * round_q);
			end
		endcase
	end

	// message block: four data words, padding, bit length
	always_comb begin
		unique case (g_idx)
			4'd0, 4'd1, 4'd2, 4'd3: m_word = msg_q[g_idx[1:0]];
			4'd4:                   m_word = md5cse_pkg::PAD_WORD;
			4'd14:                  m_word = md5cse_pkg::LEN_WORD;
			default:                m_word = '0;
		endcase
	end

	assign sum      = f_val + a_q + md5cse_pkg::MD5_K[round_q] + m_word;
	assign rot_wide = {sum, sum} << md5cse_pkg::MD5_S[{phase, round_q[1:0]}];
	assign new_b    = b_q + rot_wide[63:32];

	assign fin[0] = md5cse_pkg::IV_A + a_q;
	assign fin[1] = md5cse_pkg::IV_B + b_q;
	assign fin[2] = md5cse_pkg::IV_C + c_q;
	assign fin[3] = md5cse_pkg::IV_D + d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.start) begin
			round_q <= '0;
		end else if (cmd.round) begin
			round_q <= round_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			seed_q <= seed;
			for (int k = 0; k < 4; k++) msg_q[k] <= '0;
		end else if (cmd.start) begin
			msg_q[0] <= seed_q;
			msg_q[1] <= {msg_q[1][31:8], cmd.group_byte};
			a_q <= md5cse_pkg::IV_A;
			b_q <= md5cse_pkg::IV_B;
			c_q <= md5cse_pkg::IV_C;
			d_q <= md5cse_pkg::IV_D;
		end else if (cmd.round) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= new_b;
		end else if (cmd.finish) begin
			for (int k = 0; k < 4; k++) begin
				hash_q[k] <= fin[k];
				msg_q[k]  <= fin[k];
			end
		end
	end

	assign sts.last_round = (round_q == 6'd63);
	assign slot_word      = hash_q[cmd.word_sel];

endmodule
`default_nettype wire

FILE: hdl/md5cse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module md5cse_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [5:0]            slot_index,
	output logic                  last_word,
	output md5cse_pkg::cmd_t      cmd,
	input  wire md5cse_pkg::sts_t sts
);

	localparam int GW = md5cse_pkg::GROUP_W;

	md5cse_pkg::state_t state_q;
	logic [GW-1:0] group_q;
	logic [1:0]    word_q;
	logic [5:0]    count_q;

	logic count_room;
	logic more_words;
	logic more_groups;
	logic in_acc;
	logic out_acc;

	// room for one more result after the current one
	assign count_room  = (7'(count_q) + 7'd1) < 7'(md5cse_pkg::MAX_RESULTS);
	assign more_words  = (word_q != 2'd3) && count_room &&
		((8'(group_q) + 8'(word_q) + 8'd1) < 8'(md5cse_pkg::SLOT_COUNT));
	assign more_groups = count_room &&
		((8'(group_q) + 8'd4) < 8'(md5cse_pkg::SLOT_COUNT));

	assign in_ready   = (state_q == md5cse_pkg::S_IDLE);
	assign out_valid  = (state_q == md5cse_pkg::S_EMIT);
	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign slot_index = 6'(group_q + GW'(word_q));
	assign last_word  = !more_words && !more_groups;

	assign cmd.load_seed  = in_acc;
	assign cmd.start      = (state_q == md5cse_pkg::S_INIT);
	assign cmd.round      = (state_q == md5cse_pkg::S_ROUND);
	assign cmd.finish     = (state_q == md5cse_pkg::S_FINISH);
	assign cmd.word_sel   = word_q;
	assign cmd.group_byte = 8'(group_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5cse_pkg::S_IDLE;
			group_q <= GW'(md5cse_pkg::FIRST_SLOT);
			word_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				md5cse_pkg::S_IDLE: begin
					if (in_acc) begin
						group_q <= GW'(md5cse_pkg::FIRST_SLOT);
						word_q  <= '0;
						count_q <= '0;
						if (md5cse_pkg::RANGE_NONEMPTY) state_q <= md5cse_pkg::S_INIT;
					end
				end
				md5cse_pkg::S_INIT: begin
					state_q <= md5cse_pkg::S_ROUND;
				end
				md5cse_pkg::S_ROUND: begin
					if (sts.last_round) state_q <= md5cse_pkg::S_FINISH;
				end
				md5cse_pkg::S_FINISH: begin
					word_q  <= '0;
					state_q <= md5cse_pkg::S_EMIT;
				end
				md5cse_pkg::S_EMIT: begin
					if (out_acc) begin
						count_q <= count_q + 6'd1;
						if (more_words) begin
							word_q <= word_q + 2'd1;
						end else if (more_groups) begin
							group_q <= group_q + GW'(4);
							state_q <= md5cse_pkg::S_INIT;
						end else begin
							group_q <= GW'(md5cse_pkg::FIRST_SLOT);
							state_q <= md5cse_pkg::S_IDLE;
						end
					end
				end
				default: begin
					state_q <= md5cse_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/md5cse_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "md5_chained_seed_expander_defines.svh"
module md5cse_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  slot_index,
	input wire logic [31:0] slot_word,
	input wire logic        last_word
);

	// never idle while a result is on offer
	`MD5CSE_ASSERT_NOW(a_idle_no_out, out_valid, !in_ready)
	// a new seed blocks the input
	`MD5CSE_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
	// the input only reopens after the last item
	`MD5CSE_ASSERT_NEXT(a_stay_busy, out_valid && out_ready && !last_word, !in_ready)
	// a stalled result holds
	`MD5CSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(slot_index) && $stable(slot_word) && $stable(last_word))

endmodule

bind md5_chained_seed_expander md5cse_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.slot_index (slot_index),
	.slot_word  (slot_word),
	.last_word  (last_word)
);
`default_nettype wire

FILE: bench/tb_md5_chained_seed_expander.sv
`timescale 1ns / 1ps

module tb_md5_chained_seed_expander;

	// clock, reset and run length
	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 9;
	localparam int RUN_LIMIT    = 900000;
	localparam int TAIL_CYCLES  = 200;

	// slot range covered by one seed
	localparam int FIRST_GROUP  = 8;
	localparam int END_SLOT     = 64;
	localparam int WORD_CAP     = 56;

	// per-cycle idling chance, in percent
	localparam int IDLE_PCT     = 15;
	localparam int RANDOM_SEEDS = 158;

	// input side: a run of seeds offered with no gap at all
	localparam int SEED_QUIET_FROM = 40;
	localparam int SEED_QUIET_TO   = 100;

	// output side: one long hold-off, and a stretch that never stalls
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 3000;
	localparam int QUIET_FROM   = 1200;
	localparam int QUIET_TO     = 2400;

	// additive constants of the 64 rounds
	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// left-rotate amounts, four per quarter of the rounds
	localparam int ROUND_SHIFT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	// four 32-bit words, element 0 in the low bits
	typedef logic [3:0][31:0] word4_t;

	// one state word as it should leave the block
	typedef struct {
		logic [5:0]  slot;
		logic [31:0] word;
		logic        last;
	} slot_word_t;

	// holds the state words still owed by the block, oldest first,
	// and works out the whole chain of digests for every seed taken
	class expansion_scoreboard;
		slot_word_t  owed_words[$];
		int unsigned failures = 0;

		// digest of a 16-byte message padded to one block
		function word4_t md5_digest(word4_t msg);
			logic [31:0] blk [16];
			logic [31:0] a, b, c, d, f;
			int          g, q, sh;
			word4_t      dig;
			for (int j = 0; j < 16; j++)
				blk[j] = '0;
			for (int j = 0; j < 4; j++)
				blk[j] = msg[j];
			blk[4]  = 32'h0000_0080;
			blk[14] = 32'd128;
			a = 32'h67452301;
			b = 32'hefcdab89;
			c = 32'h98badcfe;
			d = 32'h10325476;
			for (int r = 0; r < 64; r++) begin
				q = r / 16;
				case (q)
					0: begin
						f = (b & c) | (~b & d);
						g = r;
					end
					1: begin
						f = (d & b) | (~d & c);
						g = (5 * r + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * r + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * r) % 16;
					end
				endcase
				f  = f + a + ROUND_K[r] + blk[g];
				sh = ROUND_SHIFT[q * 4 + r % 4];
				a  = d;
				d  = c;
				c  = b;
				b  = b + ((f << sh) | (f >> (32 - sh)));
			end
			dig[0] = 32'h67452301 + a;
			dig[1] = 32'hefcdab89 + b;
			dig[2] = 32'h98badcfe + c;
			dig[3] = 32'h10325476 + d;
			return dig;
		endfunction

		// a seed went in: queue every slot word it yields
		function void note_seed(logic [31:0] s);
			word4_t     msg;
			word4_t     dig;
			slot_word_t item;
			int         n;
			msg = '0;
			n   = 0;
			for (int grp = FIRST_GROUP; grp < END_SLOT && n < WORD_CAP; grp += 4) begin
				msg[0]       = s;
				msg[1][7:0]  = grp[7:0];
				dig          = md5_digest(msg);
				msg          = dig;
				for (int w = 0; w < 4 && grp + w < END_SLOT && n < WORD_CAP; w++) begin
					item.slot = 6'(grp + w);
					item.word = dig[w];
					item.last = 1'b0;
					owed_words.push_back(item);
					n++;
				end
			end
			if (n > 0)
				owed_words[owed_words.size() - 1].last = 1'b1;
		endfunction

		// a slot word came out: compare with the oldest one owed
		function void check_word(logic [5:0] slot, logic [31:0] word, logic last);
			slot_word_t want;
			if (owed_words.size() == 0) begin
				$error("unexpected item: slot_index %0d slot_word %h last_word %b",
					slot, word, last);
				failures++;
				return;
			end
			want = owed_words.pop_front();
			if (want.slot !== slot) begin
				$error("slot_index: expected %0d, actual %0d", want.slot, slot);
				failures++;
			end
			if (want.word !== word) begin
				$error("slot_word: expected %h, actual %h", want.word, word);
				failures++;
			end
			if (want.last !== last) begin
				$error("last_word: expected %b, actual %b", want.last, last);
				failures++;
			end
		endfunction
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [31:0] seed       = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [5:0]  slot_index;
	logic [31:0] slot_word;
	logic        last_word;

	expansion_scoreboard expansion = new();
	int unsigned         cycle_count = 0;
	int unsigned         seeds_offered = 0;

	md5_chained_seed_expander DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.seed       (seed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_index (slot_index),
		.slot_word  (slot_word),
		.last_word  (last_word)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// called at the edge where the previous seed went in (or just after reset);
	// an idle gap lowers valid once, otherwise the next seed follows straight on
	task automatic offer_seed(input logic [31:0] s);
		int gap;
		gap = 0;
		if (seeds_offered < SEED_QUIET_FROM || seeds_offered >= SEED_QUIET_TO) begin
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		end
		seeds_offered++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		seed     <= s;
		// valid and payload stay put until the block takes the item
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expansion.note_seed(s);
	endtask

	// output side: takes state words, stalls at random, holds off once for
	// a long stretch so the output register fills and the input stalls
	initial begin
		int unsigned taken;
		int unsigned hold_left;
		bit          held;
		taken     = 0;
		hold_left = 0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				expansion.check_word(slot_index, slot_word, last_word);
				taken++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held && taken >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (taken >= QUIET_FROM && taken < QUIET_TO) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// watchdog: a run that hangs ends here
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [31:0] corner_seeds [$];
		corner_seeds = '{
			32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
			32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff,
			32'hffff_0000, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h1234_5678
		};

		// reset held low at first, then released on an edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner seeds: zero, all-one, single bits, alternating bits, other patterns
		foreach (corner_seeds[k])
			offer_seed(corner_seeds[k]);

		// random seeds, each one a full 56-word expansion
		repeat (RANDOM_SEEDS)
			offer_seed($urandom());

		// last item taken at this edge: drop valid
		in_valid <= 1'b0;

		// drain every owed word, then allow for stray items to show up
		while (expansion.owed_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expansion.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/md5cse_pkg.sv
hdl/md5cse_dp.sv
hdl/md5cse_ctrl.sv
hdl/md5_chained_seed_expander.sv
hdl/md5cse_chk.sv
bench/tb_md5_chained_seed_expander.sv
